// ----- sv/alnf_pkg.sv -----
// Shared types and register indexes for the adaptive local noise filter.
package alnf_pkg;

    localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_NOISE_VARIANCE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_GCAP,
        ST_BACK,
        ST_SWEEP,
        ST_DRAIN,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DLOAD,
        ST_DIV,
        ST_RESULT
    } alnf_state_t;

    typedef struct packed {
        logic accept;
        logic setup;
        logic gcap;
        logic back;
        logic sweep;
        logic mul1;
        logic mul2;
        logic mul3;
        logic dload;
        logic div_step;
        logic result;
    } alnf_cmd_t;

    typedef struct packed {
        logic cfg_pending;
        logic has_out;
        logic out_over;
        logic back_zero;
        logic sweep_last;
        logic div_done;
        logic out_free;
    } alnf_stat_t;

endpackage

// ----- sv/alnf_ctrl.sv -----
// Sequencing state machine for the adaptive local noise filter.
module alnf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  alnf_pkg::alnf_stat_t stat,
    output alnf_pkg::alnf_cmd_t  cmd
);
    import alnf_pkg::*;

    alnf_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = !stat.cfg_pending;
                cmd.accept = s_valid && !stat.cfg_pending;
                if (cmd.accept && stat.has_out && !stat.out_over) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_GCAP;
            end
            ST_GCAP: begin
                cmd.gcap   = 1'b1;
                state_next = ST_BACK;
            end
            ST_BACK: begin
                cmd.back = 1'b1;
                if (stat.back_zero) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.mul3   = 1'b1;
                state_next = ST_DLOAD;
            end
            ST_DLOAD: begin
                cmd.dload  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_RESULT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/alnf_dp.sv -----
// Datapath of the adaptive local noise filter: line store, window sweep, arithmetic and divider.
module alnf_dp #(
    parameter int WINDOW     = 25,
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [23:0]          cfg_wdata,
    input  logic [7:0]           s_pixel_in,
    input  alnf_pkg::alnf_cmd_t  cmd,
    output alnf_pkg::alnf_stat_t stat,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [7:0]           m_pixel_out,
    output logic                 m_frame_end
);
    import alnf_pkg::*;

    localparam int HALF = WINDOW / 2;
    localparam int WIN  = 2 * HALF + 1;
    localparam int RING = WIN * MAX_WIDTH;
    localparam int AW   = $clog2(RING);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + HALF * MAX_WIDTH + HALF + 1);
    localparam int RX   = HW + 1;
    localparam int CX   = WW + 1;
    localparam int HB   = $clog2(HALF + 1);
    localparam int SP   = $clog2(WIN);
    localparam int NW   = $clog2(WIN * WIN + 1);
    localparam int SW   = NW + 8;
    localparam int QW   = NW + 16;
    localparam int DW   = NW + QW + 1;
    localparam int TW   = 24 + NW + SW + 2;
    localparam int XW   = NW + QW + 26;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(RING)) begin
            s = s - (AW+1)'(RING);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + (AW+1)'(RING) - {1'b0, b};
        end
        return s[AW-1:0];
    endfunction

    // Configuration.
    logic [9:0]  width_reg;
    logic [12:0] height_reg;
    logic [23:0] nv_reg;
    logic        cfg_pending_reg;
    logic        cfg_restart;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [PW-1:0] total_reg, lag_reg;

    assign cfg_restart = cfg_wr_en &&
        (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg       <= 10'd512;
            height_reg      <= 13'd512;
            nv_reg          <= 24'd3;
            cfg_pending_reg <= 1'b1;
        end else begin
            cfg_pending_reg <= cfg_restart;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:    width_reg  <= cfg_wdata[9:0];
                    REG_FRAME_HEIGHT:   height_reg <= cfg_wdata[12:0];
                    REG_NOISE_VARIANCE: nv_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(height_reg);
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= PW'(w_eff) * PW'(h_eff);
        lag_reg   <= PW'(HALF) * PW'(w_eff) + PW'(HALF);
    end

    // Position counters.
    logic [PW-1:0] pos_reg, out_cnt_reg;
    logic [AW-1:0] wr_addr_reg, orow_addr_reg;
    logic [CW-1:0] ocol_reg;
    logic [RW-1:0] orow_reg;
    logic          has_out, out_over, last_out, restart;

    assign has_out  = pos_reg >= lag_reg;
    assign out_over = out_cnt_reg >= total_reg;
    assign last_out = out_cnt_reg == total_reg - PW'(1);
    assign restart  = cfg_restart || (cmd.accept && has_out && out_over) ||
                      (cmd.result && last_out);

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            pos_reg       <= '0;
            wr_addr_reg   <= '0;
            out_cnt_reg   <= '0;
            ocol_reg      <= '0;
            orow_reg      <= '0;
            orow_addr_reg <= '0;
        end else begin
            if (cmd.accept) begin
                pos_reg     <= pos_reg + PW'(1);
                wr_addr_reg <= wrap_add(wr_addr_reg, AW'(1));
            end
            if (cmd.result) begin
                out_cnt_reg <= out_cnt_reg + PW'(1);
                if (WW'(ocol_reg) == w_eff - WW'(1)) begin
                    ocol_reg      <= '0;
                    orow_reg      <= orow_reg + RW'(1);
                    orow_addr_reg <= wrap_add(orow_addr_reg, AW'(w_eff));
                end else begin
                    ocol_reg <= ocol_reg + CW'(1);
                end
            end
        end
    end

    // Line store.
    logic [7:0]    mem [RING];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] rd_addr, col_addr_reg;

    assign rd_addr = cmd.setup ? wrap_add(orow_addr_reg, AW'(ocol_reg)) : col_addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept && pos_reg < total_reg) begin
            mem[wr_addr_reg] <= s_pixel_in;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Window bounds.
    logic [RX-1:0] r0, rlo, rhi;
    logic [CX-1:0] c0, clo, chi;

    always_comb begin
        r0  = RX'(orow_reg);
        rlo = (r0 >= RX'(HALF)) ? r0 - RX'(HALF) : '0;
        rhi = (r0 + RX'(HALF) < RX'(h_eff)) ? r0 + RX'(HALF) : RX'(h_eff) - RX'(1);
        c0  = CX'(ocol_reg);
        clo = (c0 >= CX'(HALF)) ? c0 - CX'(HALF) : '0;
        chi = (c0 + CX'(HALF) < CX'(w_eff)) ? c0 + CX'(HALF) : CX'(w_eff) - CX'(1);
    end

    // Window sweep and accumulation.
    logic [AW-1:0] row_addr_reg, row_next, clo_reg;
    logic [HB-1:0] back_cnt_reg;
    logic [SP-1:0] rspan_reg, cspan_reg, r_cnt_reg, c_cnt_reg;
    logic          acc_en_reg;
    logic [SW-1:0] s_reg;
    logic [QW-1:0] q_reg;
    logic [NW-1:0] n_reg;
    logic [7:0]    g_reg;

    assign row_next = wrap_add(row_addr_reg, AW'(w_eff));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg <= 1'b0;
        end else begin
            acc_en_reg <= cmd.sweep;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            row_addr_reg <= orow_addr_reg;
            back_cnt_reg <= HB'(r0 - rlo);
            rspan_reg    <= SP'(rhi - rlo);
            cspan_reg    <= SP'(chi - clo);
            clo_reg      <= AW'(clo);
            s_reg        <= '0;
            q_reg        <= '0;
            n_reg        <= '0;
        end
        if (cmd.gcap) begin
            g_reg <= rdata_reg;
        end
        if (cmd.back) begin
            if (back_cnt_reg != '0) begin
                row_addr_reg <= wrap_sub(row_addr_reg, AW'(w_eff));
                back_cnt_reg <= back_cnt_reg - HB'(1);
            end else begin
                col_addr_reg <= wrap_add(row_addr_reg, clo_reg);
                c_cnt_reg    <= '0;
                r_cnt_reg    <= '0;
            end
        end
        if (cmd.sweep) begin
            if (c_cnt_reg == cspan_reg) begin
                c_cnt_reg    <= '0;
                r_cnt_reg    <= r_cnt_reg + SP'(1);
                row_addr_reg <= row_next;
                col_addr_reg <= wrap_add(row_next, clo_reg);
            end else begin
                c_cnt_reg    <= c_cnt_reg + SP'(1);
                col_addr_reg <= wrap_add(col_addr_reg, AW'(1));
            end
        end
        if (acc_en_reg) begin
            s_reg <= s_reg + SW'(rdata_reg);
            q_reg <= q_reg + QW'(rdata_reg) * QW'(rdata_reg);
            n_reg <= n_reg + NW'(1);
        end
    end

    // Arithmetic stages.
    logic [NW+QW-1:0]        nq_reg;
    logic [2*SW-1:0]         ss_reg;
    logic [24+NW-1:0]        nvn_reg;
    logic [SW-1:0]           gn_reg;
    logic signed [DW-1:0]    d_reg;
    logic [24+2*NW-1:0]      nvnn_reg;
    logic signed [TW-1:0]    t_reg;
    logic signed [SW:0]      gms;
    logic [DW+6:0]           dg_reg;
    logic                    use_mean_reg;
    logic signed [XW-1:0]    num;

    assign gms = $signed({1'b0, gn_reg}) - $signed({1'b0, s_reg});
    assign num = $signed({{(XW-DW-15){1'b0}}, dg_reg, 8'd0}) -
                 $signed({{(XW-TW){t_reg[TW-1]}}, t_reg});

    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            nq_reg  <= (NW+QW)'(n_reg) * (NW+QW)'(q_reg);
            ss_reg  <= (2*SW)'(s_reg) * (2*SW)'(s_reg);
            nvn_reg <= (24+NW)'(nv_reg) * (24+NW)'(n_reg);
            gn_reg  <= SW'(g_reg) * SW'(n_reg);
        end
        if (cmd.mul2) begin
            d_reg    <= $signed({1'b0, nq_reg}) - $signed({1'b0, ss_reg});
            nvnn_reg <= (24+2*NW)'(nvn_reg) * (24+2*NW)'(n_reg);
            t_reg    <= $signed({{(TW-24-NW){1'b0}}, nvn_reg}) * TW'(gms);
        end
        if (cmd.mul3) begin
            use_mean_reg <= (d_reg <= 0) ||
                (XW'(nvnn_reg) >= XW'({d_reg[DW-2:0], 8'd0}));
            dg_reg <= (DW+7)'(d_reg[DW-2:0]) * (DW+7)'(g_reg);
        end
    end

    // Restoring divider: saturation test, then eight quotient bits.
    logic [XW-1:0] rem_reg, dvs_reg;
    logic [7:0]    quo_reg;
    logic [3:0]    div_cnt_reg;
    logic          sat_reg, ge;

    assign ge = rem_reg >= dvs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.dload) begin
            div_cnt_reg <= 4'd9;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dload) begin
            quo_reg <= '0;
            sat_reg <= 1'b0;
            if (use_mean_reg) begin
                rem_reg <= XW'(s_reg);
                dvs_reg <= XW'(n_reg) << 8;
            end else begin
                rem_reg <= num[XW-1] ? '0 : XW'(num);
                dvs_reg <= XW'(d_reg[DW-2:0]) << 16;
            end
        end
        if (cmd.div_step) begin
            dvs_reg <= dvs_reg >> 1;
            if (div_cnt_reg == 4'd9) begin
                sat_reg <= ge;
            end else begin
                quo_reg <= {quo_reg[6:0], ge};
                if (ge) begin
                    rem_reg <= rem_reg - dvs_reg;
                end
            end
        end
    end

    // Output register.
    logic       m_valid_reg, fe_reg;
    logic [7:0] pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result) begin
            pix_reg <= sat_reg ? 8'hFF : quo_reg;
            fe_reg  <= last_out;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = pix_reg;
    assign m_frame_end = fe_reg;

    always_comb begin
        stat.cfg_pending = cfg_pending_reg;
        stat.has_out     = has_out;
        stat.out_over    = out_over;
        stat.back_zero   = back_cnt_reg == '0;
        stat.sweep_last  = (c_cnt_reg == cspan_reg) && (r_cnt_reg == rspan_reg);
        stat.div_done    = div_cnt_reg == '0;
        stat.out_free    = !m_valid_reg || m_ready;
    end

endmodule

// ----- sv/adaptive_local_noise_filter.sv -----
// Top level of the adaptive local noise filter: controller and datapath.
// An item that yields no result is taken without leaving the idle state. An item that yields
// a result starts a sweep over the clipped window's n pixels (up to 625 for a 25 by 25 window)
// through the line store's single read port; no new item is taken until its result is sent.
// Reset sets width and height to 512, noise variance to 3 and all position counters to zero;
// s_ready stays low for one cycle after reset and after each frame size write.
module adaptive_local_noise_filter #(
    parameter int WINDOW     = 25,
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_pixel_in,
    input  logic        s_is_pad,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pixel_out,
    output logic        m_frame_end
);
    import alnf_pkg::*;

    alnf_cmd_t  cmd;
    alnf_stat_t stat;

    // Pad items are treated like any other item, as s_is_pad is unused; only pixels beyond the frame are not stored.
    logic unused_pad;
    assign unused_pad = s_is_pad;

    alnf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    alnf_dp #(
        .WINDOW     (WINDOW),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_pixel_in  (s_pixel_in),
        .cmd         (cmd),
        .stat        (stat),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_pixel_out (m_pixel_out),
        .m_frame_end (m_frame_end)
    );

endmodule

// ----- sim/tb_adaptive_local_noise_filter.sv -----
// Self-checking testbench for the adaptive local noise filter with a predicting scoreboard.
module tb_adaptive_local_noise_filter;
    import alnf_pkg::*;

    localparam int HALF_WIN   = 12;
    localparam int RING_DEPTH = 12800;
    localparam int SETTLE     = 800;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 600;

    class noise_filter_scoreboard;
        typedef struct {
            logic [7:0] pixel;
            logic       frame_end;
        } filtered_pixel_t;

        logic [9:0]      width_reg  = 10'd512;
        logic [12:0]     height_reg = 13'd512;
        logic [23:0]     noise_reg  = 24'd3;
        byte unsigned    ring[RING_DEPTH];
        int unsigned     in_row, in_col, out_cnt;
        filtered_pixel_t expected_pixels[$];

        function new();
            foreach (ring[i]) ring[i] = 0;
            restart();
        endfunction

        function void restart();
            in_row = 0;
            in_col = 0;
            out_cnt = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > 512) return 512;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0) return 1;
            if (height_reg > 4096) return 4096;
            return height_reg;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] value);
            case (idx)
                REG_FRAME_WIDTH: begin
                    width_reg = value[9:0];
                    restart();
                end
                REG_FRAME_HEIGHT: begin
                    height_reg = value[12:0];
                    restart();
                end
                REG_NOISE_VARIANCE: begin
                    noise_reg = value;
                end
                default: ;
            endcase
        endfunction

        function logic [7:0] filter_window(int unsigned o, int unsigned w, int unsigned h);
            int unsigned r0, c0, rlo, rhi, clo, chi;
            longint n, s, q, g, d, nv, num, p;
            r0 = o / w;
            c0 = o % w;
            rlo = (r0 >= HALF_WIN) ? r0 - HALF_WIN : 0;
            rhi = (r0 + HALF_WIN < h) ? r0 + HALF_WIN : h - 1;
            clo = (c0 >= HALF_WIN) ? c0 - HALF_WIN : 0;
            chi = (c0 + HALF_WIN < w) ? c0 + HALF_WIN : w - 1;
            n = 0;
            s = 0;
            q = 0;
            for (int unsigned r = rlo; r <= rhi; r++) begin
                for (int unsigned c = clo; c <= chi; c++) begin
                    p = ring[(r * w + c) % RING_DEPTH];
                    n++;
                    s += p;
                    q += p * p;
                end
            end
            g = ring[o % RING_DEPTH];
            d = n * q - s * s;
            nv = noise_reg;
            if (d <= 0 || nv * n * n >= 256 * d) return 8'(s / n);
            num = 256 * d * g - nv * n * (g * n - s);
            if (num < 0) num = 0;
            num = num / (256 * d);
            if (num > 255) num = 255;
            return 8'(num);
        endfunction

        function void note_input(logic [7:0] pixel);
            int unsigned w, h, total, lag, pos, o;
            filtered_pixel_t e;
            w = eff_width();
            h = eff_height();
            total = w * h;
            lag = HALF_WIN * w + HALF_WIN;
            pos = in_row * w + in_col;
            if (pos < total) ring[pos % RING_DEPTH] = pixel;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (pos < lag) return;
            o = out_cnt;
            if (o >= total) begin
                restart();
                return;
            end
            e.pixel = filter_window(o, w, h);
            e.frame_end = 1'b0;
            out_cnt++;
            if (o == total - 1) begin
                e.frame_end = 1'b1;
                restart();
            end
            expected_pixels.push_back(e);
        endfunction

        function bit check_result(logic [7:0] pixel, logic frame_end, output string msg);
            filtered_pixel_t e;
            if (expected_pixels.size() == 0) begin
                msg = $sformatf("unexpected result pixel %0d frame_end %0b", pixel, frame_end);
                return 0;
            end
            e = expected_pixels.pop_front();
            if (pixel !== e.pixel || frame_end !== e.frame_end) begin
                msg = $sformatf("pixel %0d frame_end %0b, expected %0d %0b",
                                pixel, frame_end, e.pixel, e.frame_end);
                return 0;
            end
            return 1;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_pixel_in;
    logic        s_is_pad;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_pixel_out;
    logic        m_frame_end;

    noise_filter_scoreboard sb = new();
    int  error_count = 0;
    int  idle_cycles = 0;
    int  random_items = 0;
    bit  no_gaps = 0;
    bit  hold_request = 0;

    adaptive_local_noise_filter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel_in  (s_pixel_in),
        .s_is_pad    (s_is_pad),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_frame_end (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    function automatic int draw_gap();
        if (no_gaps || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL adaptive_local_noise_filter");
            $finish;
        end
    end

    initial begin : result_side
        int    stall;
        string msg;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = draw_gap();
            if (hold_request) begin
                hold_request = 0;
                stall = 2000;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (!sb.check_result(m_pixel_out, m_frame_end, msg)) report_mismatch(msg);
        end
    end

    task automatic send_item(input logic [7:0] pixel, input logic pad);
        int g;
        g = draw_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_pixel_in <= pixel;
        s_is_pad   <= pad;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(pixel);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // pattern: 0 random, 1 alternating black and white, 2 constant
    task automatic run_frame(input int w, input int h, input int nv, input int pattern,
                             input int cut, input bit press);
        int unsigned items, total;
        logic [7:0]  pixel, level;
        logic        pad;
        settle();
        write_reg(REG_FRAME_WIDTH, 24'(w));
        write_reg(REG_FRAME_HEIGHT, 24'(h));
        write_reg(REG_NOISE_VARIANCE, 24'(nv));
        total = sb.eff_width() * sb.eff_height();
        items = total + HALF_WIN * sb.eff_width() + HALF_WIN;
        if (cut > 0 && cut < items) items = cut;
        level = 8'($urandom_range(0, 255));
        for (int unsigned i = 0; i < items; i++) begin
            case (pattern)
                1: pixel = (i[0] ^ i[1]) ? 8'hFF : 8'h00;
                2: pixel = level;
                default: pixel = 8'($urandom_range(0, 255));
            endcase
            if (i < total) pad = ($urandom_range(0, 15) == 0);
            else pad = ($urandom_range(0, 7) != 0);
            if (press && i == items / 3) hold_request = 1;
            if (press && i == (5 * items) / 6) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (sb.pending() != 0);
            end
            send_item(pixel, pad);
        end
    endtask

    initial begin : stimulus
        int w, h, nv, cut, sel;
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_FRAME_WIDTH;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_pixel_in = '0;
        s_is_pad   = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_frame(3, 2, 0, 1, 0, 0);
        run_frame(0, 0, 24'hFFFFFF, 2, 0, 0);
        run_frame(2, 3, 24'hFFFFFF, 1, 0, 0);
        run_frame(1, 8191, 700, 0, 40, 0);
        no_gaps = 1;
        run_frame(1023, 1, $urandom_range(0, 4000), 0, 300, 0);
        no_gaps = 0;
        run_frame(6, 5, 300, 0, 0, 1);

        while (random_items < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            sel = $urandom_range(0, 2);
            nv = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(0, 2000)
                                             : $urandom_range(0, 24'hFFFFFF);
            cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 60) : 0;
            run_frame(w, h, nv, ($urandom_range(0, 9) == 0) ? 2 : 0, cut, 0);
            random_items += (cut > 0) ? cut : w * h + HALF_WIN * w + HALF_WIN;
        end

        settle();
        if (error_count == 0) begin
            $display("PASS adaptive_local_noise_filter");
        end else begin
            $display("FAIL adaptive_local_noise_filter");
        end
        $finish;
    end

endmodule

// ----- adaptive_local_noise_filter.f -----
sv/alnf_pkg.sv
sv/alnf_ctrl.sv
sv/alnf_dp.sv
sv/adaptive_local_noise_filter.sv
sim/tb_adaptive_local_noise_filter.sv
